>>> rtl/rita_pkg.sv
package rita_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int RADIX_W         = 6;
    localparam int MODE_W          = 2;
    localparam int CHAR_W          = 8;
    localparam int REM_W           = 5;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [MODE_W-1:0] MODE_SIGNED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOWER  = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] LOWER_OFFSET  = 8'd32;
    localparam logic [CHAR_W-1:0] ERR_CHAR      = 8'd0;
    localparam logic [REM_W-1:0]  DIGIT_TEN     = 5'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_FETCH,
        S_PUSH,
        S_ERR
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d,
                                                      input logic lower);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_TEN) begin
            c = ASCII_UPPER_A + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
            if (lower) begin
                c = c + LOWER_OFFSET;
            end
        end else begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

>>> rtl/rita_if.sv
interface rita_in_if import rita_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic [MODE_W-1:0]     mode;

    modport source (output valid, output value, output radix, output mode, input ready);
    modport sink   (input valid, input value, input radix, input mode, output ready);
endinterface

interface rita_out_if import rita_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              error;

    modport source (output valid, output character, output last, output error, input ready);
    modport sink   (input valid, input character, input last, input error, output ready);
endinterface

>>> rtl/radix_integer_to_ascii.sv
// Each digit takes a check and then one divide step per quotient bit in the shared bit-serial
// divider; sign/zero handling then finishes, and each character goes out by a memory read and a load.
// Worst case is 32 binary digits at VALUE_WIDTH=32.
// One request at a time; the next is taken once the final character is loaded.
// A bad radix gives one error character: the error state loads it into the output register once free.
// Reset (i_rst_n low, synchronous) idles the sequencer and empties the output register.
module radix_integer_to_ascii import rita_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rita_in_if.sink     i_req,
    rita_out_if.source  o_rsp
);

    localparam int DEPTH = VALUE_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(VALUE_WIDTH + 2);
    localparam int BW    = $clog2(VALUE_WIDTH);

    t_state r_state, n_state;

    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [BW-1:0]          r_bit, n_bit;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic [RADIX_W-1:0]     r_base, n_base;
    logic                   r_lower, n_lower;
    logic                   r_neg, n_neg;

    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;
    logic                   r_out_err, n_out_err;

    logic [CHAR_W-1:0]      r_mem [DEPTH];
    logic [CHAR_W-1:0]      r_mem_q;
    logic                   w_we;
    logic [CHAR_W-1:0]      w_wdata;

    logic [63:0]            w_wide;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_in_neg;
    logic                   w_bad_radix;
    logic [RADIX_W-1:0]     w_rem_sh;
    logic [RADIX_W-1:0]     w_rem_diff;
    logic                   w_ge;
    logic [REM_W-1:0]       w_rem_nx;
    logic [CW-1:0]          w_total;
    logic [CW-1:0]          w_last_idx;
    logic                   w_out_free;

    assign w_wide      = {{(64 - IN_VALUE_W){1'b0}}, i_req.value};
    assign w_val       = w_wide[VALUE_WIDTH-1:0];
    assign w_in_neg    = (i_req.mode == MODE_SIGNED) && w_val[VALUE_WIDTH-1];
    assign w_mag       = w_in_neg ? (~w_val + VALUE_WIDTH'(1)) : w_val;
    assign w_bad_radix = (i_req.radix < RADIX_MIN) || (i_req.radix > RADIX_MAX);

    // restoring division step, one quotient bit per cycle
    assign w_rem_sh   = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_ge       = (w_rem_sh >= r_base);
    assign w_rem_diff = w_rem_sh - r_base;
    assign w_rem_nx   = w_ge ? w_rem_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];

    assign w_total    = r_cnt + {{(CW-1){1'b0}}, r_neg};
    assign w_last_idx = w_total - CW'(1);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.character = r_out_char;
    assign o_rsp.last      = r_out_last;
    assign o_rsp.error     = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_quot     <= n_quot;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_ptr      <= n_ptr;
        r_base     <= n_base;
        r_lower    <= n_lower;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    // digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_cnt[AW-1:0]] <= w_wdata;
        end
        r_mem_q <= r_mem[r_ptr];
    end

    always_comb begin
        n_state     = r_state;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_base      = r_base;
        n_lower     = r_lower;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        w_we        = 1'b0;
        w_wdata     = ASCII_ZERO;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (w_bad_radix) begin
                        n_state = S_ERR;
                    end else begin
                        n_quot  = w_mag;
                        n_base  = i_req.radix;
                        n_lower = (i_req.mode >= MODE_LOWER);
                        n_neg   = w_in_neg && (i_req.radix == RADIX_DEC);
                        n_cnt   = '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_quot == '0) begin
                    if (r_cnt == '0) begin
                        // zero value converts to a single '0'
                        w_we    = 1'b1;
                        w_wdata = ASCII_ZERO;
                        n_cnt   = CW'(1);
                    end
                    n_state = S_SIGN;
                end else begin
                    n_rem   = '0;
                    n_bit   = BW'(VALUE_WIDTH - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = w_rem_nx;
                n_quot = {r_quot[VALUE_WIDTH-2:0], w_ge};
                n_bit  = r_bit - BW'(1);
                if (r_bit == '0) begin
                    w_we    = 1'b1;
                    w_wdata = digit_char(w_rem_nx, r_lower);
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_CHECK;
                end
            end
            S_SIGN: begin
                if (r_neg) begin
                    w_we    = 1'b1;
                    w_wdata = ASCII_MINUS;
                end
                n_cnt   = w_total;
                n_ptr   = w_last_idx[AW-1:0];
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_mem_q;
                    n_out_last  = (r_ptr == '0);
                    n_out_err   = 1'b0;
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - AW'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ERR_CHAR;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rita_checker.sv
module rita_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last,
    input logic       i_out_error
);

    // a request holds the block busy for at least the cycle after it
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready did not drop after a request");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_error) |-> (i_out_last && i_out_char == 8'd0))
        else $error("error result not a single null character");

    a_digit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_error) |-> (i_out_char != 8'd0))
        else $error("null character on a good conversion");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_last)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

endmodule

bind radix_integer_to_ascii rita_checker u_rita_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_char  (o_rsp.character),
    .i_out_last  (o_rsp.last),
    .i_out_error (o_rsp.error)
);
